[rtl/angle_bias_kalman_filter_assert.svh]
// Assertion macros for the angle and bias Kalman filter.
// They expect signals named clk and rst_n in the scope where they are used.
`ifndef ANGLE_BIAS_KALMAN_FILTER_ASSERT_SVH
`define ANGLE_BIAS_KALMAN_FILTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ABKF_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("abkf: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ABKF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("abkf: next-cycle check failed");

`endif

[rtl/abkf_pkg.sv]
package abkf_pkg;

    // Serial multiplier: a is up to 35 bits signed, b up to 33 bits signed.
    localparam int MUL_A_W   = 35;
    localparam int MUL_B_W   = 33;
    localparam int MUL_P_W   = 69;
    localparam int MUL_R_W   = 40;
    localparam int MUL_STEPS = 33;
    localparam int MUL_CNT_W = 6;

    // Serial divider: 62-bit dividend magnitude, 32-bit positive divisor.
    localparam int DIV_Q_W   = 62;
    localparam int DIV_D_W   = 32;
    localparam int DIV_STEPS = 62;
    localparam int DIV_CNT_W = 6;

    localparam int SUM_W = 42;
    localparam int CFG_W = 30;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_NOISE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_NOISE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD      = 2'd3;

    localparam logic [CFG_W-1:0] RST_ANGLE_NOISE = 30'd1073742;
    localparam logic [CFG_W-1:0] RST_BIAS_NOISE  = 30'd3221225;
    localparam logic [CFG_W-1:0] RST_MEAS_NOISE  = 30'd536870912;
    localparam logic [CFG_W-1:0] RST_PERIOD      = 30'd10737418;

    localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;

    typedef struct packed {
        logic                       start;
        logic signed [MUL_A_W-1:0]  a;
        logic signed [MUL_B_W-1:0]  b;
    } mul_req_t;

    typedef struct packed {
        logic                       done;
        logic signed [MUL_R_W-1:0]  result;
    } mul_rsp_t;

    typedef struct packed {
        logic                       start;
        logic signed [31:0]         num;
        logic [DIV_D_W-1:0]         den;
    } div_req_t;

    typedef struct packed {
        logic                       done;
        logic signed [31:0]         result;
    } div_rsp_t;

    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [31:0] r;
        if (v > 42'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (v < -42'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [25:0] sat_angle(input logic signed [31:0] v);
        logic signed [25:0] r;
        if (v > 32'sd33554431)
            r = 26'sh1FF_FFFF;
        else if (v < -32'sd33554432)
            r = 26'sh200_0000;
        else
            r = v[25:0];
        return r;
    endfunction

    function automatic logic signed [27:0] sat_rate(input logic signed [32:0] v);
        logic signed [27:0] r;
        if (v > 33'sd134217727)
            r = 28'sh7FF_FFFF;
        else if (v < -33'sd134217728)
            r = 28'sh800_0000;
        else
            r = v[27:0];
        return r;
    endfunction

endpackage

[rtl/abkf_serial_mul.sv]
module abkf_serial_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  abkf_pkg::mul_req_t req,
    output abkf_pkg::mul_rsp_t rsp
);

    logic                                 busy_reg;
    logic                                 fin_reg;
    logic                                 done_reg;
    logic [abkf_pkg::MUL_CNT_W-1:0]       cnt_reg;
    logic [abkf_pkg::MUL_A_W-1:0]         amag_reg;
    logic [abkf_pkg::MUL_A_W:0]           hi_reg;
    logic [abkf_pkg::MUL_B_W-1:0]         lo_reg;
    logic                                 neg_reg;
    logic signed [abkf_pkg::MUL_R_W-1:0]  result_reg;

    logic [abkf_pkg::MUL_A_W:0]           sum;
    logic [abkf_pkg::MUL_P_W-1:0]         rounded;
    logic [abkf_pkg::MUL_R_W-1:0]         mag;

    // One bit of the multiplier magnitude is consumed per cycle, LSB first.
    assign sum = lo_reg[0] ? (hi_reg + {1'b0, amag_reg}) : hi_reg;
    assign rounded = {hi_reg, lo_reg} + abkf_pkg::MUL_P_W'(64'd536870912);
    assign mag = {1'b0, rounded[abkf_pkg::MUL_P_W-1:30]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + abkf_pkg::MUL_CNT_W'(1);
                if (cnt_reg == abkf_pkg::MUL_CNT_W'(abkf_pkg::MUL_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            amag_reg <= req.a[abkf_pkg::MUL_A_W-1] ? abkf_pkg::MUL_A_W'(-req.a)
                                                    : abkf_pkg::MUL_A_W'(req.a);
            lo_reg   <= req.b[abkf_pkg::MUL_B_W-1] ? abkf_pkg::MUL_B_W'(-req.b)
                                                    : abkf_pkg::MUL_B_W'(req.b);
            hi_reg   <= '0;
            neg_reg  <= req.a[abkf_pkg::MUL_A_W-1] ^ req.b[abkf_pkg::MUL_B_W-1];
        end
        else if (busy_reg)
        begin
            hi_reg <= {1'b0, sum[abkf_pkg::MUL_A_W:1]};
            lo_reg <= {sum[0], lo_reg[abkf_pkg::MUL_B_W-1:1]};
        end
        else if (fin_reg)
        begin
            // Rounding half away from zero on the magnitude, then the sign.
            result_reg <= neg_reg ? $signed(-mag) : $signed(mag);
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = result_reg;

endmodule

[rtl/abkf_serial_div.sv]
module abkf_serial_div (
    input  logic               clk,
    input  logic               rst_n,
    input  abkf_pkg::div_req_t req,
    output abkf_pkg::div_rsp_t rsp
);

    logic                               busy_reg;
    logic                               fin_reg;
    logic                               done_reg;
    logic [abkf_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic [abkf_pkg::DIV_Q_W-1:0]       dq_reg;
    logic [abkf_pkg::DIV_D_W-1:0]       rem_reg;
    logic [abkf_pkg::DIV_D_W-1:0]       den_reg;
    logic                               neg_reg;
    logic signed [31:0]                 result_reg;

    logic [abkf_pkg::DIV_D_W:0]         rem_sh;
    logic [abkf_pkg::DIV_D_W:0]         rem_sub;
    logic                               qbit;
    logic [31:0]                        num_mag;

    // Restoring division, one quotient bit per cycle. The dividend shifts out
    // of the top of dq_reg while quotient bits enter at the bottom.
    assign rem_sh  = {rem_reg, dq_reg[abkf_pkg::DIV_Q_W-1]};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign qbit    = (rem_sh >= {1'b0, den_reg});
    assign num_mag = req.num[31] ? 32'(-req.num) : 32'(req.num);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + abkf_pkg::DIV_CNT_W'(1);
                if (cnt_reg == abkf_pkg::DIV_CNT_W'(abkf_pkg::DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dq_reg  <= {num_mag, 30'b0};
            rem_reg <= '0;
            den_reg <= req.den;
            neg_reg <= req.num[31];
        end
        else if (busy_reg)
        begin
            rem_reg <= qbit ? rem_sub[abkf_pkg::DIV_D_W-1:0] : rem_sh[abkf_pkg::DIV_D_W-1:0];
            dq_reg  <= {dq_reg[abkf_pkg::DIV_Q_W-2:0], qbit};
        end
        else if (fin_reg)
        begin
            // Quotient truncated toward zero, saturated to 32 bits.
            if (neg_reg)
                result_reg <= (dq_reg > 62'd2147483648) ? 32'sh8000_0000
                                                         : 32'(-dq_reg);
            else
                result_reg <= (dq_reg > 62'd2147483647) ? 32'sh7FFF_FFFF
                                                         : $signed(dq_reg[31:0]);
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = result_reg;

endmodule

[rtl/angle_bias_kalman_filter.sv]
// Each in-range item runs ten serial multiplies and two serial divisions one after another,
// and both divisions are skipped when the innovation variance is not positive.
// A new item is accepted only once the previous one has been handed to the output
// register: in_stall is high whenever the sequencer is not idle.
// Reset (rst_n low, asynchronous): all filter states return to zero angle and
// bias with unit covariance, registers take their defaults, no result is pending.
module angle_bias_kalman_filter #(
    parameter int NUM_AXES = 2
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Configuration write port.
    input  logic                                   cfg_we,
    input  logic [abkf_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [abkf_pkg::CFG_W-1:0]             cfg_data,
    // Input channel.
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   axis,
    input  logic signed [25:0]                     measured_angle,
    input  logic signed [27:0]                     gyro_rate,
    // Output channel.
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic                                   axis_out,
    output logic signed [25:0]                     filtered_angle,
    output logic signed [27:0]                     corrected_rate
);

    // Width of the index into the per-axis state.
    localparam int AW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

    // Sequencer states. Each multiply and divide step follows the one before it
    // in code order, so finishing a step simply moves to the next code.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_M_ANG = 4'd1;
    localparam logic [3:0] S_M_P00 = 4'd2;
    localparam logic [3:0] S_M_P01 = 4'd3;
    localparam logic [3:0] S_M_P11 = 4'd4;
    localparam logic [3:0] S_D_K0  = 4'd5;
    localparam logic [3:0] S_D_K1  = 4'd6;
    localparam logic [3:0] S_M_C00 = 4'd7;
    localparam logic [3:0] S_M_C01 = 4'd8;
    localparam logic [3:0] S_M_C10 = 4'd9;
    localparam logic [3:0] S_M_C11 = 4'd10;
    localparam logic [3:0] S_M_AE  = 4'd11;
    localparam logic [3:0] S_M_BE  = 4'd12;
    localparam logic [3:0] S_STORE = 4'd13;
    localparam logic [3:0] S_OUT   = 4'd14;

    // Configuration registers.
    logic [abkf_pkg::CFG_W-1:0] angle_noise_reg;
    logic [abkf_pkg::CFG_W-1:0] bias_noise_reg;
    logic [abkf_pkg::CFG_W-1:0] meas_noise_reg;
    logic [abkf_pkg::CFG_W-1:0] period_reg;

    // Per-axis filter state, held in flip-flops and reset to zero angle and bias with unit covariance.
    logic signed [31:0] angle_st_reg [NUM_AXES];
    logic signed [31:0] bias_st_reg  [NUM_AXES];
    logic signed [31:0] p00_st_reg   [NUM_AXES];
    logic signed [31:0] p01_st_reg   [NUM_AXES];
    logic signed [31:0] p10_st_reg   [NUM_AXES];
    logic signed [31:0] p11_st_reg   [NUM_AXES];

    // Sequencer control.
    logic [3:0] state_reg, state_next;
    logic       launched_reg, launched_next;
    logic       out_valid_reg, out_valid_next;

    // Working copy of the item and of the selected axis state.
    logic               ax_reg;
    logic [AW-1:0]      idx_reg;
    logic signed [25:0] meas_reg;
    logic signed [27:0] gyro_reg;
    logic signed [31:0] ang_reg, bias_reg;
    logic signed [31:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [31:0] k0_reg, k1_reg, t0_reg, t1_reg, err_reg;
    logic signed [25:0] fa_reg;
    logic signed [27:0] cr_reg;

    // Output register.
    logic               axis_out_reg;
    logic signed [25:0] filtered_angle_reg;
    logic signed [27:0] corrected_rate_reg;

    abkf_pkg::mul_req_t mul_req;
    abkf_pkg::mul_rsp_t mul_rsp;
    abkf_pkg::div_req_t div_req;
    abkf_pkg::div_rsp_t div_rsp;

    logic                                in_accept;
    logic                                in_range;
    logic [AW-1:0]                       in_idx;
    logic                                is_mul;
    logic signed [32:0]                  innov_var;
    logic                                var_ok;
    logic signed [abkf_pkg::MUL_R_W-1:0] prod;
    logic signed [abkf_pkg::MUL_B_W-1:0] dt_op;
    logic                                out_load;
    logic                                skip_div;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign in_range  = (int'(axis) < NUM_AXES);
    assign in_idx    = in_range ? AW'(axis) : '0;
    assign prod      = mul_rsp.result;
    assign dt_op     = $signed({3'b0, period_reg});

    // Innovation variance p00 + measure_noise, checked for a positive value
    // before the gains are divided out.
    assign innov_var = $signed({3'b0, meas_noise_reg}) + 33'(p00_reg);
    assign var_ok    = !innov_var[32] && (innov_var != 33'sd0);
    assign skip_div  = (state_reg == S_D_K0) && !launched_reg && !var_ok;

    // The output register takes a new result once the previous one has gone.
    assign out_load  = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);

    //------------------------------------------------------------------
    // Configuration writes.
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_noise_reg <= abkf_pkg::RST_ANGLE_NOISE;
            bias_noise_reg  <= abkf_pkg::RST_BIAS_NOISE;
            meas_noise_reg  <= abkf_pkg::RST_MEAS_NOISE;
            period_reg      <= abkf_pkg::RST_PERIOD;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                abkf_pkg::REG_ANGLE_NOISE: angle_noise_reg <= cfg_data;
                abkf_pkg::REG_BIAS_NOISE:  bias_noise_reg  <= cfg_data;
                abkf_pkg::REG_MEAS_NOISE:  meas_noise_reg  <= cfg_data;
                abkf_pkg::REG_PERIOD:      period_reg      <= cfg_data;
                default:                   period_reg      <= period_reg;
            endcase
        end
    end

    //------------------------------------------------------------------
    // Operand selection for the shared serial multiplier and divider.
    //------------------------------------------------------------------
    always_comb
    begin
        is_mul    = 1'b1;
        mul_req.a = '0;
        mul_req.b = dt_op;
        unique case (state_reg)
            S_M_ANG: mul_req.a = 35'(gyro_reg) - 35'(bias_reg);
            S_M_P00: mul_req.a = $signed({5'b0, angle_noise_reg})
                                 - 35'(p01_reg) - 35'(p10_reg);
            S_M_P01: mul_req.a = 35'(p11_reg);
            S_M_P11: mul_req.a = $signed({5'b0, bias_noise_reg});
            S_M_C00:
            begin
                mul_req.a = 35'(t0_reg);
                mul_req.b = 33'(k0_reg);
            end
            S_M_C01:
            begin
                mul_req.a = 35'(t1_reg);
                mul_req.b = 33'(k0_reg);
            end
            S_M_C10:
            begin
                mul_req.a = 35'(t0_reg);
                mul_req.b = 33'(k1_reg);
            end
            S_M_C11:
            begin
                mul_req.a = 35'(t1_reg);
                mul_req.b = 33'(k1_reg);
            end
            S_M_AE:
            begin
                mul_req.a = 35'(err_reg);
                mul_req.b = 33'(k0_reg);
            end
            S_M_BE:
            begin
                mul_req.a = 35'(err_reg);
                mul_req.b = 33'(k1_reg);
            end
            default: is_mul = 1'b0;
        endcase
        mul_req.start = is_mul && !launched_reg;

        div_req.num   = (state_reg == S_D_K1) ? p10_reg : p00_reg;
        div_req.den   = innov_var[abkf_pkg::DIV_D_W-1:0];
        div_req.start = ((state_reg == S_D_K0) || (state_reg == S_D_K1))
                        && !launched_reg && var_ok;
    end

    abkf_serial_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    abkf_serial_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    //------------------------------------------------------------------
    // Sequencer.
    //------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        launched_next  = launched_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                    state_next = in_range ? S_M_ANG : S_OUT;
            end
            S_D_K0:
            begin
                if (!launched_reg)
                begin
                    // With no positive variance both gains are zero and the
                    // divisions are skipped.
                    if (var_ok)
                        launched_next = 1'b1;
                    else
                        state_next = S_M_C00;
                end
                else if (div_rsp.done)
                begin
                    launched_next = 1'b0;
                    state_next    = S_D_K1;
                end
            end
            S_D_K1:
            begin
                if (!launched_reg)
                    launched_next = 1'b1;
                else if (div_rsp.done)
                begin
                    launched_next = 1'b0;
                    state_next    = S_M_C00;
                end
            end
            S_STORE: state_next = S_OUT;
            S_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                // Multiply steps: launch once, advance when the product is ready.
                if (!launched_reg)
                    launched_next = 1'b1;
                else if (mul_rsp.done)
                begin
                    launched_next = 1'b0;
                    state_next    = state_reg + 4'd1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            launched_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            launched_reg  <= launched_next;
            out_valid_reg <= out_valid_next;
        end
    end

    //------------------------------------------------------------------
    // Working registers: loaded on accept, updated as each product or
    // quotient comes back from the shared units.
    //------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            ax_reg   <= axis;
            idx_reg  <= in_idx;
            meas_reg <= measured_angle;
            gyro_reg <= gyro_rate;
            ang_reg  <= angle_st_reg[in_idx];
            bias_reg <= bias_st_reg[in_idx];
            p00_reg  <= p00_st_reg[in_idx];
            p01_reg  <= p01_st_reg[in_idx];
            p10_reg  <= p10_st_reg[in_idx];
            p11_reg  <= p11_st_reg[in_idx];
            // Result for an axis with no filter instance.
            fa_reg   <= '0;
            cr_reg   <= gyro_rate;
        end

        if (mul_rsp.done)
        begin
            unique case (state_reg)
                S_M_ANG: ang_reg  <= abkf_pkg::sat32(42'(ang_reg) + 42'(prod));
                S_M_P00: p00_reg  <= abkf_pkg::sat32(42'(p00_reg) + 42'(prod));
                S_M_P01:
                begin
                    p01_reg <= abkf_pkg::sat32(42'(p01_reg) - 42'(prod));
                    p10_reg <= abkf_pkg::sat32(42'(p10_reg) - 42'(prod));
                end
                S_M_P11: p11_reg  <= abkf_pkg::sat32(42'(p11_reg) + 42'(prod));
                S_M_C00: p00_reg  <= abkf_pkg::sat32(42'(p00_reg) - 42'(prod));
                S_M_C01: p01_reg  <= abkf_pkg::sat32(42'(p01_reg) - 42'(prod));
                S_M_C10: p10_reg  <= abkf_pkg::sat32(42'(p10_reg) - 42'(prod));
                S_M_C11: p11_reg  <= abkf_pkg::sat32(42'(p11_reg) - 42'(prod));
                S_M_AE:  ang_reg  <= abkf_pkg::sat32(42'(ang_reg) + 42'(prod));
                S_M_BE:  bias_reg <= abkf_pkg::sat32(42'(bias_reg) + 42'(prod));
                default: ang_reg  <= ang_reg;
            endcase
        end

        if (div_rsp.done && (state_reg == S_D_K0))
            k0_reg <= div_rsp.result;

        if (skip_div)
        begin
            k0_reg <= '0;
            k1_reg <= '0;
        end

        // Entering the correction steps: keep the predicted p00 and p01 for
        // all four covariance products and form the saturated innovation.
        if (skip_div || (div_rsp.done && (state_reg == S_D_K1)))
        begin
            if (!skip_div)
                k1_reg <= div_rsp.result;
            t0_reg  <= p00_reg;
            t1_reg  <= p01_reg;
            err_reg <= abkf_pkg::sat32(42'(meas_reg) - 42'(ang_reg));
        end

        if (state_reg == S_STORE)
        begin
            fa_reg <= abkf_pkg::sat_angle(ang_reg);
            cr_reg <= abkf_pkg::sat_rate(33'(gyro_reg) - 33'(bias_reg));
        end

        if (out_load)
        begin
            axis_out_reg       <= ax_reg;
            filtered_angle_reg <= fa_reg;
            corrected_rate_reg <= cr_reg;
        end
    end

    //------------------------------------------------------------------
    // Per-axis state write-back at the end of an item.
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                angle_st_reg[i] <= '0;
                bias_st_reg[i]  <= '0;
                p00_st_reg[i]   <= abkf_pkg::Q30_ONE;
                p01_st_reg[i]   <= '0;
                p10_st_reg[i]   <= '0;
                p11_st_reg[i]   <= abkf_pkg::Q30_ONE;
            end
        end
        else if (state_reg == S_STORE)
        begin
            angle_st_reg[idx_reg] <= ang_reg;
            bias_st_reg[idx_reg]  <= bias_reg;
            p00_st_reg[idx_reg]   <= p00_reg;
            p01_st_reg[idx_reg]   <= p01_reg;
            p10_st_reg[idx_reg]   <= p10_reg;
            p11_st_reg[idx_reg]   <= p11_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign axis_out       = axis_out_reg;
    assign filtered_angle = filtered_angle_reg;
    assign corrected_rate = corrected_rate_reg;

    //------------------------------------------------------------------
    // Assertions.
    //------------------------------------------------------------------
`include "angle_bias_kalman_filter_assert.svh"

    // An accepted item always starts the sequencer.
    `ABKF_ASSERT_NEXT(a_accept_starts, in_accept, state_reg != S_IDLE)
    // A new result appears only when the sequencer hands one over.
    `ABKF_ASSERT_SAME(a_out_from_seq, $rose(out_valid_reg), $past(state_reg) == S_OUT)
    // The multiplier only answers a step that launched it.
    `ABKF_ASSERT_SAME(a_mul_owned, mul_rsp.done, launched_reg && is_mul)

endmodule

[sim/tb_angle_bias_kalman_filter.sv]
module tb_angle_bias_kalman_filter;
    timeunit 1ns;
    timeprecision 1ps;

    // Drains wait for DRAIN_CYCLES past the last result before the next register
    // write or the final verdict.
    localparam int  DRAIN_CYCLES = 700;
    // The receiver holds off this long once. That is several item times, so the
    // block fills up and stalls its input.
    localparam int  HOLD_CYCLES  = 3000;
    // This is the slowest correct run of 1550 items, plus idling and drains, taken
    // several times over.
    localparam longint CYCLE_LIMIT = 4000000;

    localparam longint Q_ONE  = 64'sd1073741824;
    localparam longint Q_HALF = 64'sd536870912;
    localparam longint S32_HI = 64'sd2147483647;
    localparam longint S32_LO = -64'sd2147483648;

    typedef struct {
        logic               axis;
        logic signed [25:0] angle;
        logic signed [27:0] rate;
    } filter_result_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [abkf_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [abkf_pkg::CFG_W-1:0]     cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic               axis;
    logic signed [25:0] measured_angle;
    logic signed [27:0] gyro_rate;
    logic               out_valid;
    logic               out_stall;
    logic               axis_out;
    logic signed [25:0] filtered_angle;
    logic signed [27:0] corrected_rate;

    angle_bias_kalman_filter dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .axis           (axis),
        .measured_angle (measured_angle),
        .gyro_rate      (gyro_rate),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .axis_out       (axis_out),
        .filtered_angle (filtered_angle),
        .corrected_rate (corrected_rate)
    );

    // This is the testbench's own copy of the filter: register values and
    // per-axis state, kept in step with every accepted item.
    logic [abkf_pkg::CFG_W-1:0] q_angle;
    logic [abkf_pkg::CFG_W-1:0] q_bias;
    logic [abkf_pkg::CFG_W-1:0] r_meas;
    logic [abkf_pkg::CFG_W-1:0] dt;
    logic signed [31:0] est_angle [2];
    logic signed [31:0] est_bias  [2];
    logic signed [31:0] p_aa [2];
    logic signed [31:0] p_ab [2];
    logic signed [31:0] p_ba [2];
    logic signed [31:0] p_bb [2];

    filter_result_t pending_results[$];

    // These are the control knobs shared by the test tasks and the traffic processes.
    bit     idle_on;
    bit     hold_long;
    int     mismatches;
    int     items_sent;
    int     results_seen;
    longint cycles;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results still pending", $time,
                     pending_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // This multiplies and rescales by 2^-30, rounding half away from zero.
    function automatic longint q30_mul(longint a, longint b);
        longint p;
        p = a * b;
        if (p < 0)
            return -((-p + Q_HALF) / Q_ONE);
        return (p + Q_HALF) / Q_ONE;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint clamp32(longint v);
        return clamp(v, S32_LO, S32_HI);
    endfunction

    // This runs one filter step on the local state and returns the result it yields.
    function automatic filter_result_t kalman_step(logic ax, logic signed [25:0] meas,
                                                   logic signed [27:0] gyro);
        filter_result_t r;
        longint period, a00, a01, a10, a11, innov_var, g0, g1, h0, h1, err, ang, bias;
        period = longint'(dt);
        bias   = est_bias[ax];
        ang    = clamp32(est_angle[ax] + q30_mul(longint'(gyro) - bias, period));

        // Propagate the covariance.
        a00 = clamp32(p_aa[ax] + q30_mul(longint'(q_angle) - p_ab[ax] - p_ba[ax], period));
        a01 = clamp32(p_ab[ax] - q30_mul(p_bb[ax], period));
        a10 = clamp32(p_ba[ax] - q30_mul(p_bb[ax], period));
        a11 = clamp32(p_bb[ax] + q30_mul(longint'(q_bias), period));

        // Both gains stay zero when the innovation variance is not positive.
        g0 = 0;
        g1 = 0;
        innov_var = longint'(r_meas) + a00;
        if (innov_var > 0)
        begin
            g0 = clamp32((a00 * Q_ONE) / innov_var);
            g1 = clamp32((a10 * Q_ONE) / innov_var);
        end

        h0  = a00;
        h1  = a01;
        a00 = clamp32(a00 - q30_mul(g0, h0));
        a01 = clamp32(a01 - q30_mul(g0, h1));
        a10 = clamp32(a10 - q30_mul(g1, h0));
        a11 = clamp32(a11 - q30_mul(g1, h1));

        // The angle error saturates before it meets the gains.
        err  = clamp32(longint'(meas) - ang);
        ang  = clamp32(ang + q30_mul(g0, err));
        bias = clamp32(bias + q30_mul(g1, err));

        est_angle[ax] = ang[31:0];
        est_bias[ax]  = bias[31:0];
        p_aa[ax] = a00[31:0];
        p_ab[ax] = a01[31:0];
        p_ba[ax] = a10[31:0];
        p_bb[ax] = a11[31:0];

        r.axis  = ax;
        r.angle = 26'(clamp(ang, -64'sd33554432, 64'sd33554431));
        r.rate  = 28'(clamp(longint'(gyro) - bias, -64'sd134217728, 64'sd134217727));
        return r;
    endfunction

    // This offers one item, with an optional idle burst first. Valid stays high after
    // acceptance so that back-to-back items need no second assignment in one step.
    // Callers lower it with stop_input once the stream pauses.
    task automatic send_item(logic ax, logic signed [25:0] meas, logic signed [27:0] gyro);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        axis           <= ax;
        measured_angle <= meas;
        gyro_rate      <= gyro;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(kalman_step(ax, meas, gyro));
        items_sent++;
    endtask

    task automatic stop_input();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // This waits until every expected result is out, then gives the block time to settle.
    task automatic drain();
        stop_input();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [abkf_pkg::CFG_IDX_W-1:0] idx,
                             logic [abkf_pkg::CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            abkf_pkg::REG_ANGLE_NOISE: q_angle = value;
            abkf_pkg::REG_BIAS_NOISE:  q_bias  = value;
            abkf_pkg::REG_MEAS_NOISE:  r_meas  = value;
            abkf_pkg::REG_PERIOD:      dt      = value;
            default: ;
        endcase
    endtask

    task automatic write_all(logic [abkf_pkg::CFG_W-1:0] qa, logic [abkf_pkg::CFG_W-1:0] qb,
                             logic [abkf_pkg::CFG_W-1:0] rm,
                             logic [abkf_pkg::CFG_W-1:0] period);
        write_reg(abkf_pkg::REG_ANGLE_NOISE, qa);
        write_reg(abkf_pkg::REG_BIAS_NOISE, qb);
        write_reg(abkf_pkg::REG_MEAS_NOISE, rm);
        write_reg(abkf_pkg::REG_PERIOD, period);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // This picks a register value, often an extreme, sometimes a small value and otherwise anywhere in range.
    function automatic logic [abkf_pkg::CFG_W-1:0] pick_cfg(int unsigned lo);
        case ($urandom_range(0, 4))
            0:       return abkf_pkg::CFG_W'(lo);
            1:       return 30'h3FFF_FFFF;
            2:       return abkf_pkg::CFG_W'($urandom_range(lo, 30'h0010_0000));
            default: return abkf_pkg::CFG_W'($urandom_range(lo, 30'h3FFF_FFFF));
        endcase
    endfunction

    // Most angles are physically plausible tilts. Some span the whole field.
    function automatic logic signed [25:0] pick_angle();
        if ($urandom_range(0, 3) == 0)
            return 26'($urandom());
        return 26'($urandom_range(0, 2 * 5898240) - 5898240);
    endfunction

    function automatic logic signed [27:0] pick_rate();
        if ($urandom_range(0, 3) == 0)
            return 28'($urandom());
        return 28'($urandom_range(0, 2 * 32768000) - 32768000);
    endfunction

    task automatic send_random_items(int count);
        for (int i = 0; i < count; i++)
            send_item(1'($urandom_range(0, 1)), pick_angle(), pick_rate());
    endtask

    // These are the field extremes on both axes, first with the reset register values
    // and then with every register at each end of its range.
    task automatic test_directed();
        send_item(1'b0, 26'sh000_0000, 28'sh000_0000);
        send_item(1'b1, 26'sh000_0000, 28'sh000_0000);
        send_item(1'b0, 26'sh1FF_FFFF, 28'sh7FF_FFFF);
        send_item(1'b0, 26'sh200_0000, 28'sh800_0000);
        send_item(1'b1, 26'sh200_0000, 28'sh7FF_FFFF);
        send_item(1'b1, 26'sh1FF_FFFF, 28'sh800_0000);
        send_item(1'b0, 26'sh155_5555, 28'sh2AA_AAAA);
        send_item(1'b1, 26'sh2AA_AAAA, 28'sh555_5555);
        drain();
        // Maximum noise and period with minimal measurement noise drive large gains.
        write_all(30'h3FFF_FFFF, 30'h3FFF_FFFF, 30'd1, 30'h3FFF_FFFF);
        for (int i = 0; i < 3; i++)
        begin
            send_item(1'b0, 26'sh1FF_FFFF, 28'sh800_0000);
            send_item(1'b1, 26'sh200_0000, 28'sh7FF_FFFF);
        end
        drain();
        // Zero process noise, the shortest period and the largest measurement noise.
        write_all(30'd0, 30'd0, 30'h3FFF_FFFF, 30'd1);
        for (int i = 0; i < 3; i++)
        begin
            send_item(1'b0, 26'sh200_0000, 28'sh7FF_FFFF);
            send_item(1'b1, 26'sh1FF_FFFF, 28'sh800_0000);
        end
        drain();
    endtask

    // Several register settings, each followed by a stretch of random items. The
    // state carries over, so covariances wander far from their reset values.
    task automatic test_random_settings();
        for (int phase = 0; phase < 6; phase++)
        begin
            write_all(pick_cfg(0), pick_cfg(0), pick_cfg(1), pick_cfg(1));
            send_random_items(200);
            drain();
        end
    endtask

    // The receiver stops for a long while as the sender keeps offering items.
    task automatic test_backpressure();
        write_all(abkf_pkg::RST_ANGLE_NOISE, abkf_pkg::RST_BIAS_NOISE,
                  abkf_pkg::RST_MEAS_NOISE, abkf_pkg::RST_PERIOD);
        hold_long = 1'b1;
        send_random_items(30);
        drain();
    endtask

    // Both sides run without idling at the end.
    task automatic test_streaming();
        idle_on = 1'b0;
        write_all(pick_cfg(0), pick_cfg(0), pick_cfg(1), pick_cfg(1));
        send_random_items(300);
        drain();
    endtask

    // The receiver's stall pattern has random bursts, one long hold on request,
    // and none once idling is switched off.
    initial
    begin
        bit stall_next;
        int span;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_long)
            begin
                stall_next = 1'b1;
                span       = HOLD_CYCLES;
                hold_long  = 1'b0;
            end
            else if (!idle_on)
            begin
                stall_next = 1'b0;
                span       = 1;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                stall_next = 1'b0;
                span       = $urandom_range(20, 80);
            end
            else
            begin
                stall_next = 1'($urandom_range(0, 1));
                span       = $urandom_range(1, 19);
            end
            out_stall <= stall_next;
            repeat (span) @(posedge clk);
        end
    end

    // Every accepted result is compared with the oldest outstanding prediction.
    always @(posedge clk)
    begin
        filter_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result axis %0d angle %0d rate %0d",
                         $time, axis_out, filtered_angle, corrected_rate);
            end
            else
            begin
                want = pending_results.pop_front();
                if (axis_out !== want.axis)
                begin
                    mismatches++;
                    $display("%0t: axis_out expected %0d actual %0d",
                             $time, want.axis, axis_out);
                end
                if (filtered_angle !== want.angle)
                begin
                    mismatches++;
                    $display("%0t: filtered_angle expected %0d actual %0d",
                             $time, want.angle, filtered_angle);
                end
                if (corrected_rate !== want.rate)
                begin
                    mismatches++;
                    $display("%0t: corrected_rate expected %0d actual %0d",
                             $time, want.rate, corrected_rate);
                end
            end
        end
    end

    initial
    begin
        cycles         = 0;
        mismatches     = 0;
        items_sent     = 0;
        results_seen   = 0;
        idle_on        = 1'b1;
        hold_long      = 1'b0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = abkf_pkg::REG_ANGLE_NOISE;
        cfg_data       = '0;
        in_valid       = 1'b0;
        axis           = 1'b0;
        measured_angle = '0;
        gyro_rate      = '0;
        q_angle        = abkf_pkg::RST_ANGLE_NOISE;
        q_bias         = abkf_pkg::RST_BIAS_NOISE;
        r_meas         = abkf_pkg::RST_MEAS_NOISE;
        dt             = abkf_pkg::RST_PERIOD;
        for (int i = 0; i < 2; i++)
        begin
            est_angle[i] = '0;
            est_bias[i]  = '0;
            p_aa[i]      = abkf_pkg::Q30_ONE;
            p_ab[i]      = '0;
            p_ba[i]      = '0;
            p_bb[i]      = abkf_pkg::Q30_ONE;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_settings();
        test_backpressure();
        test_streaming();

        if (pending_results.size() != 0)
        begin
            mismatches++;
            $display("%0t: %0d expected results never arrived", $time,
                     pending_results.size());
        end
        $display("Sent %0d items on both axes over eleven register settings,", items_sent);
        $display("checked %0d results, including a long output hold-off.", results_seen);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
